### hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, character codes and helpers for the integer literal scanner.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Default accumulator width
   localparam int ILS_VALUE_BITS = 32;

   // Result and field widths fixed by the interface
   localparam int ILS_CHAR_BITS  = 8;
   localparam int ILS_OUT_BITS   = 32;
   localparam int ILS_COUNT_BITS = 8;

   // Character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_B_LO  = 8'h62;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_A_LO  = 8'h61;
   localparam logic [7:0] CHAR_F_LO  = 8'h66;
   localparam logic [7:0] CHAR_A_UP  = 8'h41;
   localparam logic [7:0] CHAR_F_UP  = 8'h46;

   // Scan phase
   typedef enum logic [3:0] {
      PH_DONE  = 4'd0,
      PH_START = 4'd1,
      PH_LEAD  = 4'd2,
      PH_ZERO  = 4'd3,
      PH_PRE_B = 4'd4,
      PH_PRE_X = 4'd5,
      PH_DEC   = 4'd6,
      PH_BIN   = 4'd7,
      PH_HEX   = 4'd8
   } phase_type;

   // Digit decode result
   typedef struct packed {
      logic       valid;
      logic [3:0] digit;
   } digit_type;

   // Decode a decimal digit
   function automatic digit_type dec_digit(input logic [7:0] c);
      digit_type d;
      d.valid = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d.digit = c[3:0];
      return d;
   endfunction

   // Decode a hex digit in either case
   function automatic digit_type hex_digit(input logic [7:0] c);
      digit_type d;
      d.valid = 1'b0;
      d.digit = c[3:0];
      if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
         d.valid = 1'b1;
      end else if (((c >= CHAR_A_LO) && (c <= CHAR_F_LO)) ||
                   ((c >= CHAR_A_UP) && (c <= CHAR_F_UP))) begin
         d.valid = 1'b1;
         d.digit = 4'(c[3:0] + 4'd9);
      end
      return d;
   endfunction

endpackage

### hdl/integer_literal_scanner_top.sv
// ----------------------------------------------------------------------------
// integer_literal_scanner_top
// Result: registered; a result shows on rsp_* in the cycle after the request that ends it.
// Throughput: one character per cycle while the result slot is free or draining; the single-pass update sets the rate.
// Reset: synchronous; phase goes to done, sign_enable goes to 1.
// ----------------------------------------------------------------------------
module integer_literal_scanner_top #(
   parameter int VALUE_BITS = ils_pkg::ILS_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ils_pkg::ILS_CHAR_BITS-1:0]   req_char_in,
   input  logic                                req_first,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic signed [ils_pkg::ILS_OUT_BITS-1:0] rsp_value,
   output logic [ils_pkg::ILS_COUNT_BITS-1:0]  rsp_consumed,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_sign_enable
);

   localparam int CB = ils_pkg::ILS_COUNT_BITS;
   localparam int OB = ils_pkg::ILS_OUT_BITS;

   // Scan state
   ils_pkg::phase_type     phase_ff, phase_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [CB-1:0]          cnt_ff, cnt_in;
   logic                   sign_en_ff;

   // Result register
   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [OB-1:0]          rsp_value_ff, rsp_value_in;
   logic [CB-1:0]          rsp_cnt_ff, rsp_cnt_in;

   // Step signals
   logic                   req_fire;
   ils_pkg::phase_type     cur_phase;
   logic [VALUE_BITS-1:0]  cur_acc;
   logic                   cur_neg;
   logic [CB-1:0]          cur_cnt;
   ils_pkg::digit_type     dec_d, hex_d;
   logic                   bin_ok;
   logic [1:0]             cnt_inc;
   logic [CB:0]            cnt_sum;
   logic [CB-1:0]          cnt_sat;
   logic [VALUE_BITS-1:0]  acc_dec, acc_bin, acc_hex;
   logic [VALUE_BITS-1:0]  signed_acc;
   logic [OB-1:0]          ext_value;
   logic                   fin, fin_ok;

   // Accept a request whenever the result slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Apply the start-of-scan clear ahead of the phase logic
   always_comb begin
      cur_phase = req_first ? ils_pkg::PH_START : phase_ff;
      cur_acc   = req_first ? '0 : acc_ff;
      cur_neg   = req_first ? 1'b0 : neg_ff;
      cur_cnt   = req_first ? '0 : cnt_ff;
   end

   // Decode the character
   assign dec_d  = ils_pkg::dec_digit(req_char_in);
   assign hex_d  = ils_pkg::hex_digit(req_char_in);
   assign bin_ok = (req_char_in == ils_pkg::CHAR_ZERO) || (req_char_in == ils_pkg::CHAR_ONE);

   // Accumulator updates
   assign acc_dec = (cur_acc << 3) + (cur_acc << 1) + VALUE_BITS'(dec_d.digit);
   assign acc_bin = (cur_acc << 1) + VALUE_BITS'(req_char_in[0]);
   assign acc_hex = (cur_acc << 4) + VALUE_BITS'(hex_d.digit);

   // Saturating character count
   assign cnt_sum = (CB+1)'(cur_cnt) + (CB+1)'(cnt_inc);
   assign cnt_sat = cnt_sum[CB] ? {CB{1'b1}} : cnt_sum[CB-1:0];
   assign cnt_in  = cnt_sat;

   // Negate, then sign-extend or cut to the result width
   assign signed_acc = cur_neg ? (VALUE_BITS'(0) - cur_acc) : cur_acc;
   generate
      if (VALUE_BITS >= OB) begin : g_cut
         assign ext_value = signed_acc[OB-1:0];
      end else begin : g_ext
         assign ext_value = {{(OB-VALUE_BITS){signed_acc[VALUE_BITS-1]}}, signed_acc};
      end
   endgenerate

   // Next phase
   always_comb begin
      phase_in = cur_phase;
      unique case (cur_phase)
         ils_pkg::PH_START: begin
            if (sign_en_ff && (req_char_in == ils_pkg::CHAR_MINUS)) begin
               phase_in = ils_pkg::PH_LEAD;
            end else if (req_char_in == ils_pkg::CHAR_ZERO) begin
               phase_in = ils_pkg::PH_ZERO;
            end else if (dec_d.valid) begin
               phase_in = ils_pkg::PH_DEC;
            end else begin
               phase_in = ils_pkg::PH_DONE;
            end
         end
         ils_pkg::PH_LEAD: begin
            if (req_char_in == ils_pkg::CHAR_ZERO) begin
               phase_in = ils_pkg::PH_ZERO;
            end else if (dec_d.valid) begin
               phase_in = ils_pkg::PH_DEC;
            end else begin
               phase_in = ils_pkg::PH_DONE;
            end
         end
         ils_pkg::PH_ZERO: begin
            if (req_char_in == ils_pkg::CHAR_B_LO) begin
               phase_in = ils_pkg::PH_PRE_B;
            end else if (req_char_in == ils_pkg::CHAR_X_LO) begin
               phase_in = ils_pkg::PH_PRE_X;
            end else begin
               phase_in = dec_d.valid ? ils_pkg::PH_DEC : ils_pkg::PH_DONE;
            end
         end
         ils_pkg::PH_DEC:   phase_in = dec_d.valid ? ils_pkg::PH_DEC : ils_pkg::PH_DONE;
         ils_pkg::PH_PRE_B: phase_in = bin_ok ? ils_pkg::PH_BIN : ils_pkg::PH_DONE;
         ils_pkg::PH_PRE_X: phase_in = hex_d.valid ? ils_pkg::PH_HEX : ils_pkg::PH_DONE;
         ils_pkg::PH_BIN:   phase_in = bin_ok ? ils_pkg::PH_BIN : ils_pkg::PH_DONE;
         ils_pkg::PH_HEX:   phase_in = hex_d.valid ? ils_pkg::PH_HEX : ils_pkg::PH_DONE;
         ils_pkg::PH_DONE:  phase_in = ils_pkg::PH_DONE;
         default:           phase_in = ils_pkg::PH_DONE;
      endcase
   end

   // Datapath and result per phase
   always_comb begin
      acc_in  = cur_acc;
      neg_in  = cur_neg;
      cnt_inc = 2'd0;
      fin     = 1'b0;
      fin_ok  = 1'b1;
      unique case (cur_phase)
         ils_pkg::PH_START, ils_pkg::PH_LEAD: begin
            if ((cur_phase == ils_pkg::PH_START) && sign_en_ff &&
                (req_char_in == ils_pkg::CHAR_MINUS)) begin
               neg_in  = 1'b1;
               cnt_inc = 2'd1;
            end else if (dec_d.valid) begin
               acc_in  = VALUE_BITS'(dec_d.digit);
               cnt_inc = 2'd1;
            end else begin
               fin    = 1'b1;
               fin_ok = 1'b0;
            end
         end
         ils_pkg::PH_ZERO, ils_pkg::PH_DEC: begin
            if ((cur_phase == ils_pkg::PH_ZERO) &&
                ((req_char_in == ils_pkg::CHAR_B_LO) ||
                 (req_char_in == ils_pkg::CHAR_X_LO))) begin
               cnt_inc = 2'd0;
            end else if (dec_d.valid) begin
               acc_in  = acc_dec;
               cnt_inc = 2'd1;
            end else begin
               fin = 1'b1;
            end
         end
         ils_pkg::PH_PRE_B: begin
            if (bin_ok) begin
               acc_in  = VALUE_BITS'(req_char_in[0]);
               cnt_inc = 2'd2;
            end else begin
               fin = 1'b1;
            end
         end
         ils_pkg::PH_PRE_X: begin
            if (hex_d.valid) begin
               acc_in  = VALUE_BITS'(hex_d.digit);
               cnt_inc = 2'd2;
            end else begin
               fin = 1'b1;
            end
         end
         ils_pkg::PH_BIN: begin
            if (bin_ok) begin
               acc_in  = acc_bin;
               cnt_inc = 2'd1;
            end else begin
               fin = 1'b1;
            end
         end
         ils_pkg::PH_HEX: begin
            if (hex_d.valid) begin
               acc_in  = acc_hex;
               cnt_inc = 2'd1;
            end else begin
               fin = 1'b1;
            end
         end
         ils_pkg::PH_DONE: begin
            fin = 1'b0;
         end
         default: begin
            fin = 1'b0;
         end
      endcase
      rsp_ok_in    = fin_ok;
      rsp_value_in = fin_ok ? ext_value : '0;
      rsp_cnt_in   = fin_ok ? cur_cnt : '0;
   end

   // Hold scan state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ils_pkg::PH_DONE;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         cnt_ff     <= '0;
         sign_en_ff <= 1'b1;
      end else begin
         if (req_fire) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            cnt_ff   <= cnt_in;
         end
         if (csr_valid && csr_ready) begin
            sign_en_ff <= csr_sign_enable;
         end
      end
   end

   // Load the result register, drop it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && fin) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_value_ff <= rsp_value_in;
         rsp_cnt_ff   <= rsp_cnt_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_consumed = rsp_cnt_ff;

   // A failed scan reports zero value and zero count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_value == '0) && (rsp_consumed == '0))
      else $error("failed scan with nonzero payload");

   // A good literal always consumed at least one character
   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> (rsp_consumed != '0))
      else $error("good literal with zero count");

   // A request ending a scan leaves the scanner done
   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      req_fire && fin |=> (phase_ff == ils_pkg::PH_DONE) && rsp_valid)
      else $error("scan end did not reach done");

   // Characters while done produce no result
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_first && (phase_ff == ils_pkg::PH_DONE)
      |=> rsp_valid == $past(rsp_valid && !rsp_ready))
      else $error("result produced while done");

   // A start character never leaves the scanner in the start phase
   a_start_moves: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_first |=> (phase_ff != ils_pkg::PH_START))
      else $error("scanner stuck in start");

endmodule

### verif/integer_literal_scanner_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_literal_scanner_top_tb
// Streams characters into the scanner through a bursty sender, drains results
// through a receiver with its own stall pattern, and checks every result
// against an in-bench scanner model, across both settings of sign_enable.
// ----------------------------------------------------------------------------
module integer_literal_scanner_top_tb;

   localparam int VB        = ils_pkg::ILS_VALUE_BITS;
   localparam int CHB       = ils_pkg::ILS_CHAR_BITS;
   localparam int OUTB      = ils_pkg::ILS_OUT_BITS;
   localparam int CNTB      = ils_pkg::ILS_COUNT_BITS;
   localparam int COUNT_MAX = 255;
   localparam int HOLD_OFF  = 400;
   localparam int PHASE_LEN = 210;

   typedef struct {
      logic [CHB-1:0] code;
      logic           first;
   } char_item_type;

   typedef struct {
      logic                   ok;
      logic signed [OUTB-1:0] value;
      logic [CNTB-1:0]        consumed;
   } literal_result_type;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_pattern_type;

   // clock, reset and block inputs, all known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CHB-1:0]         req_char_in = '0;
   logic                   req_first = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_ok;
   logic signed [OUTB-1:0] rsp_value;
   logic [CNTB-1:0]        rsp_consumed;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_sign_enable = 1'b0;

   // scanner model state
   ils_pkg::phase_type scan_phase = ils_pkg::PH_DONE;
   logic [VB-1:0]      scan_acc = '0;
   logic               scan_neg = 1'b0;
   logic [CNTB-1:0]    scan_count = '0;
   logic               minus_allowed = 1'b1;

   char_item_type      char_queue[$];
   literal_result_type expected_literals[$];
   char_item_type      next_char;
   bit                 start_pending = 1'b0;
   int                 queued_total = 0;
   int                 fail_count = 0;

   // sender and receiver pacing
   bit             req_taken = 1'b0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             hold_off_serial = 0;
   int             hold_off_seen = 0;
   int             hold_off_left = 0;
   int             pattern_left = 0;
   int             rx_cycle = 0;
   rx_pattern_type pattern_mode = RX_ALWAYS;

   integer_literal_scanner_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_first       (req_first),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_value       (rsp_value),
      .rsp_consumed    (rsp_consumed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_sign_enable (csr_sign_enable)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Digit value of a hex character in either case, -1 if none
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= ils_pkg::CHAR_ZERO && c <= ils_pkg::CHAR_NINE)
         return int'(c - ils_pkg::CHAR_ZERO);
      if (c >= ils_pkg::CHAR_A_LO && c <= ils_pkg::CHAR_F_LO)
         return int'(c - ils_pkg::CHAR_A_LO) + 10;
      if (c >= ils_pkg::CHAR_A_UP && c <= ils_pkg::CHAR_F_UP)
         return int'(c - ils_pkg::CHAR_A_UP) + 10;
      return -1;
   endfunction

   function automatic logic [CNTB-1:0] sat_count(input logic [CNTB-1:0] c, input int n);
      int sum;
      sum = int'(c) + n;
      return (sum > COUNT_MAX) ? CNTB'(COUNT_MAX) : CNTB'(sum);
   endfunction

   // Advance the scanner model by one accepted character
   task automatic scan_char(input logic [7:0] c, input logic first_flag);
      int                   h;
      bit                   is_dec;
      bit                   ends;
      bit                   good;
      logic [VB-1:0]        mag;
      logic signed [VB-1:0] sval;
      literal_result_type   res;
      h      = nibble_of(c);
      is_dec = (c >= ils_pkg::CHAR_ZERO) && (c <= ils_pkg::CHAR_NINE);
      ends   = 1'b0;
      good   = 1'b1;
      if (first_flag) begin
         scan_phase = ils_pkg::PH_START;
         scan_acc   = '0;
         scan_neg   = 1'b0;
         scan_count = '0;
      end
      case (scan_phase)
         ils_pkg::PH_START, ils_pkg::PH_LEAD: begin
            if (scan_phase == ils_pkg::PH_START && minus_allowed &&
                c == ils_pkg::CHAR_MINUS) begin
               scan_neg   = 1'b1;
               scan_count = sat_count(scan_count, 1);
               scan_phase = ils_pkg::PH_LEAD;
            end else if (c == ils_pkg::CHAR_ZERO) begin
               scan_acc   = '0;
               scan_count = sat_count(scan_count, 1);
               scan_phase = ils_pkg::PH_ZERO;
            end else if (is_dec) begin
               scan_acc   = VB'(c - ils_pkg::CHAR_ZERO);
               scan_count = sat_count(scan_count, 1);
               scan_phase = ils_pkg::PH_DEC;
            end else begin
               ends = 1'b1;
               good = 1'b0;
            end
         end
         ils_pkg::PH_ZERO, ils_pkg::PH_DEC: begin
            if (scan_phase == ils_pkg::PH_ZERO && c == ils_pkg::CHAR_B_LO) begin
               scan_phase = ils_pkg::PH_PRE_B;
            end else if (scan_phase == ils_pkg::PH_ZERO && c == ils_pkg::CHAR_X_LO) begin
               scan_phase = ils_pkg::PH_PRE_X;
            end else if (is_dec) begin
               scan_acc   = VB'(scan_acc * 10 + (c - ils_pkg::CHAR_ZERO));
               scan_count = sat_count(scan_count, 1);
               scan_phase = ils_pkg::PH_DEC;
            end else begin
               ends = 1'b1;
            end
         end
         ils_pkg::PH_PRE_B: begin
            if (c == ils_pkg::CHAR_ZERO || c == ils_pkg::CHAR_ONE) begin
               scan_acc   = VB'(c - ils_pkg::CHAR_ZERO);
               scan_count = sat_count(scan_count, 2);
               scan_phase = ils_pkg::PH_BIN;
            end else begin
               ends = 1'b1;
            end
         end
         ils_pkg::PH_PRE_X: begin
            if (h >= 0) begin
               scan_acc   = VB'(h);
               scan_count = sat_count(scan_count, 2);
               scan_phase = ils_pkg::PH_HEX;
            end else begin
               ends = 1'b1;
            end
         end
         ils_pkg::PH_BIN: begin
            if (c == ils_pkg::CHAR_ZERO || c == ils_pkg::CHAR_ONE) begin
               scan_acc   = VB'({scan_acc, 1'b0} + (c - ils_pkg::CHAR_ZERO));
               scan_count = sat_count(scan_count, 1);
            end else begin
               ends = 1'b1;
            end
         end
         ils_pkg::PH_HEX: begin
            if (h >= 0) begin
               scan_acc   = VB'({scan_acc, 4'h0} + h);
               scan_count = sat_count(scan_count, 1);
            end else begin
               ends = 1'b1;
            end
         end
         default: ;
      endcase
      // emit the literal on the first character that cannot continue it
      if (ends) begin
         mag = scan_acc;
         if (scan_neg) mag = -mag;
         sval         = mag;
         res.ok       = good;
         res.value    = good ? OUTB'(sval) : '0;
         res.consumed = good ? scan_count : '0;
         expected_literals.push_back(res);
         scan_phase = ils_pkg::PH_DONE;
      end
   endtask

   // Queue one character; the first after start_pending carries the first flag
   task automatic queue_char(input logic [7:0] c);
      char_item_type it;
      it.code  = c;
      it.first = start_pending;
      start_pending = 1'b0;
      char_queue.push_back(it);
      queued_total++;
   endtask

   task automatic queue_text(input string s);
      start_pending = 1'b1;
      for (int i = 0; i < s.len(); i++) queue_char(s[i]);
   endtask

   // A character that ends any literal
   function automatic logic [7:0] stop_char();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return " ";
         2: return ",";
         3: return "g";
         4: return "Z";
         default: return 8'($urandom_range(128, 255));
      endcase
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(ils_pkg::CHAR_ZERO + v);
      if ($urandom_range(0, 1)) return 8'(ils_pkg::CHAR_A_LO + v - 10);
      return 8'(ils_pkg::CHAR_A_UP + v - 10);
   endfunction

   // Queue one random literal, mostly well formed; long_run forces a long binary one
   task automatic queue_literal(input bit long_run);
      int kind;
      int len;
      bit neg;
      kind = long_run ? 5 : $urandom_range(0, 9);
      neg  = ($urandom_range(0, 2) == 0);
      start_pending = 1'b1;
      case (kind)
         0, 1, 2: begin
            if (neg) queue_char(ils_pkg::CHAR_MINUS);
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               queue_char(8'(ils_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            queue_char(stop_char());
         end
         3, 4: begin
            if (neg) queue_char(ils_pkg::CHAR_MINUS);
            queue_char(ils_pkg::CHAR_ZERO);
            queue_char(ils_pkg::CHAR_X_LO);
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) queue_char(hex_char());
            queue_char(stop_char());
         end
         5, 6: begin
            if (neg) queue_char(ils_pkg::CHAR_MINUS);
            queue_char(ils_pkg::CHAR_ZERO);
            queue_char(ils_pkg::CHAR_B_LO);
            len = long_run ? 300 : $urandom_range(1, 36);
            for (int i = 0; i < len; i++)
               queue_char(8'(ils_pkg::CHAR_ZERO + $urandom_range(0, 1)));
            queue_char(stop_char());
         end
         7: begin
            // short forms: lone sign, prefix without digit, or bare zero
            if (neg) queue_char(ils_pkg::CHAR_MINUS);
            case ($urandom_range(0, 3))
               0: ;
               1: begin
                  queue_char(ils_pkg::CHAR_ZERO);
                  queue_char(ils_pkg::CHAR_B_LO);
               end
               2: begin
                  queue_char(ils_pkg::CHAR_ZERO);
                  queue_char(ils_pkg::CHAR_X_LO);
               end
               default: queue_char(ils_pkg::CHAR_ZERO);
            endcase
            queue_char(stop_char());
         end
         8: begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) queue_char(8'($urandom_range(0, 255)));
         end
         default: begin
            // abandoned: the next first drops it without a result
            if (neg) queue_char(ils_pkg::CHAR_MINUS);
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
               queue_char(8'(ils_pkg::CHAR_ZERO + $urandom_range(0, 9)));
         end
      endcase
      // trailing characters after the literal are ignored
      if (kind < 8 && $urandom_range(0, 1)) begin
         len = $urandom_range(1, 2);
         for (int i = 0; i < len; i++) queue_char(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic queue_random_phase();
      int start_total;
      start_total = queued_total;
      while (queued_total - start_total < PHASE_LEN) queue_literal(1'b0);
   endtask

   // Wait until every request is in and every result is out
   task automatic drain();
      while (char_queue.size() != 0 || req_valid || expected_literals.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sign_enable(input logic v);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_sign_enable <= v;
      do @(posedge clock); while (!csr_ready);
      minus_allowed = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender: offer queued requests in bursts, hold each until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (char_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            next_char = char_queue.pop_front();
            req_valid   <= 1'b1;
            req_char_in <= next_char.code;
            req_first   <= next_char.first;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Receiver: stall on a changing pattern, with an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_off_serial != hold_off_seen) begin
            hold_off_seen = hold_off_serial;
            hold_off_left = HOLD_OFF;
         end
         if (pattern_left == 0) begin
            pattern_mode = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
         end else begin
            pattern_left--;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (pattern_mode)
               RX_ALWAYS:   rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_MOSTLY:   rsp_ready <= ($urandom_range(0, 7) != 0);
               RX_PERIODIC: rsp_ready <= ((rx_cycle % 4) != 0);
               default:     rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // Monitor: check each taken result, then feed each taken request to the model
   always @(posedge clock) begin
      literal_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_literals.size() == 0) begin
               $error("unexpected result: ok=%0d value=%0d consumed=%0d",
                      rsp_ok, rsp_value, rsp_consumed);
               fail_count++;
            end else begin
               want = expected_literals.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("ok: expected %0d, actual %0d", want.ok, rsp_ok);
                  fail_count++;
               end
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_consumed !== want.consumed) begin
                  $error("consumed: expected %0d, actual %0d", want.consumed, rsp_consumed);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            scan_char(req_char_in, req_first);
            req_taken = 1'b1;
         end
      end
   end

   // Stimulus sequence
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: failures, prefixes without digit, leading zero, all bases
      write_sign_enable(1'b1);
      queue_text("z");
      queue_text("-");
      queue_char(8'h00);
      queue_text("0b2q");
      queue_text("0xg");
      queue_text("0123;");
      queue_text("-0xFa");
      queue_char(8'hff);
      queue_text("12");
      queue_text("0b101 ");
      drain();

      // minus rejected while signs are off
      write_sign_enable(1'b0);
      queue_text("-5");
      queue_random_phase();
      hold_off_serial++;
      drain();

      // extreme values, wrap and count saturation
      write_sign_enable(1'b1);
      queue_text("0xFFFFFFFF,");
      queue_text("-0x80000000 ");
      queue_text("4294967296 ");
      queue_text("-0x7fffffff;");
      queue_literal(1'b1);
      queue_random_phase();
      drain();

      write_sign_enable(1'b0);
      queue_random_phase();
      hold_off_serial++;
      drain();

      write_sign_enable(1'b1);
      queue_random_phase();
      drain();
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("integer_literal_scanner_top regression: pass");
      end else begin
         $display("integer_literal_scanner_top regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("integer_literal_scanner_top regression: fail");
      $finish;
   end

endmodule
